// File: src/iirdf2t_pkg.sv
`default_nettype none
package iirdf2t_pkg;

	localparam int ORDER_DEF  = 3;

	localparam int SMP_W      = 16;
	localparam int COEF_W     = 18;
	localparam int PROD_W     = COEF_W + SMP_W;
	localparam int DL_W       = 40;
	localparam int ACC_W      = 42;
	localparam int FRAC_W     = 14;

	localparam int NCOEF      = 7;
	localparam int COEF_IDX_W = 3;

	// register / coefficient slot numbers
	localparam logic [COEF_IDX_W-1:0] COEF_B0 = 3'd0;
	localparam logic [COEF_IDX_W-1:0] COEF_B1 = 3'd1;
	localparam logic [COEF_IDX_W-1:0] COEF_B2 = 3'd2;
	localparam logic [COEF_IDX_W-1:0] COEF_B3 = 3'd3;
	localparam logic [COEF_IDX_W-1:0] COEF_A1 = 3'd4;
	localparam logic [COEF_IDX_W-1:0] COEF_A2 = 3'd5;
	localparam logic [COEF_IDX_W-1:0] COEF_A3 = 3'd6;

	localparam logic signed [COEF_W-1:0] B0_RST   = 18'sd16384;
	localparam logic signed [COEF_W-1:0] COEF_RST = 18'sd0;

	typedef struct packed {
		logic en;
		logic sub;
	} mac_ctl_t;

endpackage
`default_nettype wire

// File: src/iirdf2t_mac.sv
`default_nettype none
module iirdf2t_mac (
	input  wire                                         clk,
	input  wire                                         arst_n,
	input  wire iirdf2t_pkg::mac_ctl_t                  ctl,
	input  wire logic signed [iirdf2t_pkg::COEF_W-1:0]  coef,
	input  wire logic signed [iirdf2t_pkg::SMP_W-1:0]   opnd,
	input  wire logic signed [iirdf2t_pkg::ACC_W-1:0]   base,
	output logic signed [iirdf2t_pkg::ACC_W-1:0]        acc
);

	logic signed [iirdf2t_pkg::PROD_W-1:0] prod;
	logic signed [iirdf2t_pkg::ACC_W-1:0]  prod_x;
	logic signed [iirdf2t_pkg::ACC_W-1:0]  acc_q;

	assign prod   = coef * opnd;
	assign prod_x = iirdf2t_pkg::ACC_W'(prod);
	assign acc    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.en) begin
			if (ctl.sub) begin
				acc_q <= acc_q - prod_x;
			end else begin
				acc_q <= base + prod_x;
			end
		end
	end

endmodule
`default_nettype wire

// File: src/iirdf2t_ctrl.sv
`default_nettype none
module iirdf2t_ctrl #(
	parameter int ORDER = iirdf2t_pkg::ORDER_DEF
) (
	input  wire                                           clk,
	input  wire                                           arst_n,
	input  wire                                           in_valid,
	output logic                                          in_stall,
	input  wire logic signed [iirdf2t_pkg::SMP_W-1:0]     sample_in,
	output logic                                          out_valid,
	input  wire                                           out_stall,
	output logic signed [iirdf2t_pkg::SMP_W-1:0]          sample_out,
	output logic                                          clipped,
	output logic [iirdf2t_pkg::COEF_IDX_W-1:0]            coef_sel,
	output iirdf2t_pkg::mac_ctl_t                         mac_ctl,
	output logic signed [iirdf2t_pkg::SMP_W-1:0]          mac_opnd,
	output logic signed [iirdf2t_pkg::ACC_W-1:0]          mac_base,
	input  wire logic signed [iirdf2t_pkg::ACC_W-1:0]     acc
);

	localparam int TAP_W = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam logic [TAP_W:0]   ORDER_V  = (TAP_W + 1)'(ORDER);
	localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(ORDER - 1);

	localparam int AW = iirdf2t_pkg::ACC_W;
	localparam int DW = iirdf2t_pkg::DL_W;
	localparam int SW = iirdf2t_pkg::SMP_W;

	localparam logic signed [AW-1:0] DL_MAX = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [AW-1:0] DL_MIN = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};
	localparam logic signed [AW-1:0] Y_MAX  = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
	localparam logic signed [AW-1:0] Y_MIN  = {{(AW-SW+1){1'b1}}, {(SW-1){1'b0}}};
	localparam logic signed [AW-1:0] HALF   = AW'(1) <<< (iirdf2t_pkg::FRAC_W - 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MACY  = 3'd1;
	localparam logic [2:0] ST_ROUND = 3'd2;
	localparam logic [2:0] ST_FWD   = 3'd3;
	localparam logic [2:0] ST_FBK   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]              state_q;
	logic [TAP_W-1:0]        tap_q;
	logic signed [SW-1:0]    x_q;
	logic signed [SW-1:0]    y_q;
	logic                    clip_q;
	logic signed [DW-1:0]    dl_q [ORDER];
	logic                    out_valid_q;
	logic signed [SW-1:0]    sample_out_q;
	logic                    clipped_q;

	logic [TAP_W:0]          tap_nx;
	logic [TAP_W-1:0]        tap_prev;
	logic signed [AW-1:0]    rnd;
	logic signed [SW-1:0]    y_sat;
	logic                    y_clip;
	logic signed [DW-1:0]    dl_sat;
	logic                    dl_clip;
	logic                    out_free;

	assign tap_nx   = {1'b0, tap_q} + (TAP_W + 1)'(1);
	assign tap_prev = tap_q - TAP_W'(1);
	assign out_free = !out_valid_q || !out_stall;

	// round half up: floor((acc + 2^13) / 2^14)
	assign rnd = (acc + HALF) >>> iirdf2t_pkg::FRAC_W;

	always_comb begin
		y_clip = 1'b0;
		y_sat  = rnd[SW-1:0];
		if (rnd > Y_MAX) begin
			y_sat  = Y_MAX[SW-1:0];
			y_clip = 1'b1;
		end else if (rnd < Y_MIN) begin
			y_sat  = Y_MIN[SW-1:0];
			y_clip = 1'b1;
		end
	end

	always_comb begin
		dl_clip = 1'b0;
		dl_sat  = acc[DW-1:0];
		if (acc > DL_MAX) begin
			dl_sat  = DL_MAX[DW-1:0];
			dl_clip = 1'b1;
		end else if (acc < DL_MIN) begin
			dl_sat  = DL_MIN[DW-1:0];
			dl_clip = 1'b1;
		end
	end

	always_comb begin
		coef_sel    = iirdf2t_pkg::COEF_B0;
		mac_ctl.en  = 1'b0;
		mac_ctl.sub = 1'b0;
		mac_opnd    = x_q;
		mac_base    = AW'(dl_q[0]);
		case (state_q)
			ST_MACY: begin
				mac_ctl.en = 1'b1;
			end
			ST_FWD: begin
				coef_sel   = iirdf2t_pkg::COEF_B1 + iirdf2t_pkg::COEF_IDX_W'(tap_q);
				mac_ctl.en = 1'b1;
				// last tap has no upstream delay term
				if (tap_nx < ORDER_V) begin
					mac_base = AW'(dl_q[tap_nx[TAP_W-1:0]]);
				end else begin
					mac_base = '0;
				end
			end
			ST_FBK: begin
				coef_sel    = iirdf2t_pkg::COEF_A1 + iirdf2t_pkg::COEF_IDX_W'(tap_q);
				mac_ctl.en  = 1'b1;
				mac_ctl.sub = 1'b1;
				mac_opnd    = y_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_q       <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < ORDER; i++) begin
				dl_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						tap_q   <= '0;
						clip_q  <= 1'b0;
						state_q <= ST_MACY;
					end
				end
				ST_MACY: begin
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					clip_q  <= clip_q | y_clip;
					state_q <= ST_FWD;
				end
				ST_FWD: begin
					// acc still holds the previous tap's finished update
					if (tap_q != '0) begin
						dl_q[tap_prev] <= dl_sat;
						clip_q         <= clip_q | dl_clip;
					end
					state_q <= ST_FBK;
				end
				ST_FBK: begin
					if (tap_q == LAST_TAP) begin
						state_q <= ST_DONE;
					end else begin
						tap_q   <= tap_q + TAP_W'(1);
						state_q <= ST_FWD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						dl_q[tap_q] <= dl_sat;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			x_q <= sample_in;
		end
		if (state_q == ST_ROUND) begin
			y_q <= y_sat;
		end
		if (state_q == ST_DONE && out_free) begin
			sample_out_q <= y_q;
			clipped_q    <= clip_q | dl_clip;
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped    = clipped_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == ST_MACY))
		else $error("accepted request did not start the sequence");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (out_valid && state_q == ST_IDLE))
		else $error("finished request not presented");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, tap_q} < ORDER_V))
		else $error("tap counter beyond filter order");

	a_clip_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MACY) |-> !clip_q)
		else $error("clip flag carried over from previous request");

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FWD || state_q == ST_FBK) |-> (in_stall && mac_ctl.en))
		else $error("tap step without stall or MAC enable");

endmodule
`default_nettype wire

// File: src/iir_filter_df2t_top.sv
`default_nettype none
// Third-order IIR filter, direct form II transposed, on one shared 18x16
// multiply-accumulate unit. Coefficients b0..b3 and a1..a3 are signed Q3.14
// (already divided by a0) written through cfg_wr_en/cfg_index/cfg_data; the
// user must write them only while the filter is idle, which is unenforced;
// indexes beyond a3 are ignored. An accepted sample takes one MAC for
// s0+b0*x, a round and clamp step, two MACs per delay tap and a final step
// that writes the last tap and loads the output register when it is free.
// in_stall is high for the whole computation; a finished result waits in the
// output register so the next sample can be taken while it is still stalled.
// Delay taps saturate at 40 bits, the output at 16 bits; clipped flags either.
module iir_filter_df2t_top #(
	parameter int ORDER = iirdf2t_pkg::ORDER_DEF
) (
	input  wire                                            clk,
	input  wire                                            arst_n,
	input  wire                                            cfg_wr_en,
	input  wire logic [iirdf2t_pkg::COEF_IDX_W-1:0]        cfg_index,
	input  wire logic [iirdf2t_pkg::COEF_W-1:0]            cfg_data,
	input  wire                                            in_valid,
	output logic                                           in_stall,
	input  wire logic signed [iirdf2t_pkg::SMP_W-1:0]      sample_in,
	output logic                                           out_valid,
	input  wire                                            out_stall,
	output logic signed [iirdf2t_pkg::SMP_W-1:0]           sample_out,
	output logic                                           clipped
);

	logic signed [iirdf2t_pkg::COEF_W-1:0]  coef_q [iirdf2t_pkg::NCOEF];
	logic [iirdf2t_pkg::COEF_IDX_W-1:0]     coef_sel;
	logic signed [iirdf2t_pkg::COEF_W-1:0]  coef;
	iirdf2t_pkg::mac_ctl_t                  mac_ctl;
	logic signed [iirdf2t_pkg::SMP_W-1:0]   mac_opnd;
	logic signed [iirdf2t_pkg::ACC_W-1:0]   mac_base;
	logic signed [iirdf2t_pkg::ACC_W-1:0]   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= iirdf2t_pkg::B0_RST;
			for (int i = 1; i < iirdf2t_pkg::NCOEF; i++) begin
				coef_q[i] <= iirdf2t_pkg::COEF_RST;
			end
		end else if (cfg_wr_en && (cfg_index <= iirdf2t_pkg::COEF_A3)) begin
			coef_q[cfg_index] <= $signed(cfg_data);
		end
	end

	always_comb begin
		if (coef_sel <= iirdf2t_pkg::COEF_A3) begin
			coef = coef_q[coef_sel];
		end else begin
			coef = '0;
		end
	end

	iirdf2t_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (coef),
		.opnd   (mac_opnd),
		.base   (mac_base),
		.acc    (acc)
	);

	iirdf2t_ctrl #(
		.ORDER (ORDER)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample_in  (sample_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.sample_out (sample_out),
		.clipped    (clipped),
		.coef_sel   (coef_sel),
		.mac_ctl    (mac_ctl),
		.mac_opnd   (mac_opnd),
		.mac_base   (mac_base),
		.acc        (acc)
	);

endmodule
`default_nettype wire
